@@ hdl/snlc_pkg.sv @@
package snlc_pkg;

    // Default list capacity per graph row.
    localparam int MAX_DEGREE_DEF = 64;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_PUSH_A = 2'd0;
    localparam logic [1:0] OP_PUSH_B = 2'd1;
    localparam logic [1:0] OP_CLOSE  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // Verdict kinds of a result beat.
    localparam logic KIND_ROW   = 1'b0;
    localparam logic KIND_GRAPH = 1'b1;

    // Input beat.
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] neighbor;
        logic [15:0] vertex_count_a;
        logic [15:0] vertex_count_b;
    } t_item;

    // Result beat.
    typedef struct packed {
        logic verdict_kind;
        logic same;
        logic row_overflow;
    } t_res;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_CMP_RD,
        S_CMP_CHK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ovf_set;
        logic ins_load;
        logic ins_shift;
        logic ins_place;
        logic cmp_init;
        logic cmp_rd;
        logic cmp_next;
        logic row_emit;
        logic row_same;
        logic graph_emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sel_full;
        logic pos_zero;
        logic rd_gt;
        logic row_ok;
        logic k_done;
        logic rd_eq;
    } t_sts;

endpackage

@@ hdl/snlc_ctrl.sv @@
module snlc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_operation,
    input  snlc_pkg::t_sts    i_sts,
    output snlc_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    snlc_pkg::t_state r_state;
    snlc_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= snlc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            snlc_pkg::S_IDLE: begin
                if (i_accept) begin
                    case (i_operation)
                        snlc_pkg::OP_PUSH_A, snlc_pkg::OP_PUSH_B: begin
                            if (!i_sts.sel_full) begin
                                n_state = snlc_pkg::S_INS_RD;
                            end
                        end
                        snlc_pkg::OP_CLOSE: begin
                            if (i_sts.row_ok) begin
                                n_state = snlc_pkg::S_CMP_RD;
                            end
                        end
                        default: n_state = snlc_pkg::S_IDLE;
                    endcase
                end
            end
            snlc_pkg::S_INS_RD: begin
                n_state = i_sts.pos_zero ? snlc_pkg::S_IDLE : snlc_pkg::S_INS_CMP;
            end
            snlc_pkg::S_INS_CMP: begin
                n_state = i_sts.rd_gt ? snlc_pkg::S_INS_RD : snlc_pkg::S_IDLE;
            end
            snlc_pkg::S_CMP_RD: begin
                n_state = i_sts.k_done ? snlc_pkg::S_IDLE : snlc_pkg::S_CMP_CHK;
            end
            snlc_pkg::S_CMP_CHK: begin
                n_state = i_sts.rd_eq ? snlc_pkg::S_CMP_RD : snlc_pkg::S_IDLE;
            end
            default: n_state = snlc_pkg::S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            snlc_pkg::S_IDLE: begin
                if (i_accept) begin
                    case (i_operation)
                        snlc_pkg::OP_PUSH_A, snlc_pkg::OP_PUSH_B: begin
                            if (i_sts.sel_full) begin
                                o_cmd.ovf_set = 1'b1;
                            end else begin
                                o_cmd.ins_load = 1'b1;
                            end
                        end
                        snlc_pkg::OP_CLOSE: begin
                            if (i_sts.row_ok) begin
                                o_cmd.cmp_init = 1'b1;
                            end else begin
                                o_cmd.row_emit = 1'b1;
                            end
                        end
                        default: o_cmd.graph_emit = 1'b1;
                    endcase
                end
            end
            snlc_pkg::S_INS_RD: begin
                // At the bottom of the list, with no entry below, the value lands here.
                o_cmd.ins_place = i_sts.pos_zero;
            end
            snlc_pkg::S_INS_CMP: begin
                o_cmd.ins_shift = i_sts.rd_gt;
                o_cmd.ins_place = !i_sts.rd_gt;
            end
            snlc_pkg::S_CMP_RD: begin
                o_cmd.row_emit = i_sts.k_done;
                o_cmd.row_same = i_sts.k_done;
                o_cmd.cmp_rd   = !i_sts.k_done;
            end
            snlc_pkg::S_CMP_CHK: begin
                o_cmd.row_emit = !i_sts.rd_eq;
                o_cmd.cmp_next = i_sts.rd_eq;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != snlc_pkg::S_IDLE);

endmodule

@@ hdl/snlc_dpath.sv @@
module snlc_dpath #(
    parameter int MAX_DEGREE = snlc_pkg::MAX_DEGREE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  snlc_pkg::t_item   i_item,
    input  snlc_pkg::t_cmd    i_cmd,
    output snlc_pkg::t_sts    o_sts,
    output logic              o_res_strobe,
    output snlc_pkg::t_res    o_res
);

    localparam int CNT_W = $clog2(MAX_DEGREE + 1);
    localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_DEGREE);

    logic [15:0]      mem_a [MAX_DEGREE];
    logic [15:0]      mem_b [MAX_DEGREE];

    logic [CNT_W-1:0] r_cnt_a;
    logic [CNT_W-1:0] r_cnt_b;
    logic             r_ovf;
    logic             r_all_same;
    logic             r_sel;
    logic [15:0]      r_value;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_k;
    logic [15:0]      r_rd_a;
    logic [15:0]      r_rd_b;
    logic             r_strobe;
    snlc_pkg::t_res   r_res;

    logic [CNT_W-1:0] pos_m1;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [15:0]      rd_sel;
    logic [15:0]      wr_data;
    logic             wr_en;
    logic             push_b;

    // Read and write addressing of the two lists.
    assign pos_m1  = r_pos - 1'b1;
    assign rd_addr = i_cmd.cmp_rd ? r_k[IDX_W-1:0] : pos_m1[IDX_W-1:0];
    assign wr_addr = r_pos[IDX_W-1:0];
    assign rd_sel  = r_sel ? r_rd_b : r_rd_a;
    assign wr_data = i_cmd.ins_shift ? rd_sel : r_value;
    assign wr_en   = i_cmd.ins_shift | i_cmd.ins_place;
    assign push_b  = (i_item.operation == snlc_pkg::OP_PUSH_B);

    // List memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (wr_en && !r_sel) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr_en && r_sel) begin
            mem_b[wr_addr] <= wr_data;
        end
        r_rd_a <= mem_a[rd_addr];
        r_rd_b <= mem_b[rd_addr];
    end

    // Insertion and compare pointers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_load) begin
            r_sel   <= push_b;
            r_value <= i_item.neighbor;
            r_pos   <= push_b ? r_cnt_b : r_cnt_a;
        end else if (i_cmd.ins_shift) begin
            r_pos <= pos_m1;
        end
        if (i_cmd.cmp_init) begin
            r_k <= '0;
        end else if (i_cmd.cmp_next) begin
            r_k <= r_k + 1'b1;
        end
    end

    // Row counts, overflow and graph flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_ovf      <= 1'b0;
            r_all_same <= 1'b1;
        end else begin
            if (i_cmd.ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.ins_place && !r_sel) begin
                r_cnt_a <= r_cnt_a + 1'b1;
            end
            if (i_cmd.ins_place && r_sel) begin
                r_cnt_b <= r_cnt_b + 1'b1;
            end
            if (i_cmd.row_emit || i_cmd.graph_emit) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.row_emit && !i_cmd.row_same) begin
                r_all_same <= 1'b0;
            end
            if (i_cmd.graph_emit) begin
                r_all_same <= 1'b1;
            end
        end
    end

    // Result strobe for one cycle per verdict.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.row_emit | i_cmd.graph_emit;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_emit) begin
            r_res.verdict_kind <= snlc_pkg::KIND_ROW;
            r_res.same         <= i_cmd.row_same;
            r_res.row_overflow <= r_ovf;
        end else if (i_cmd.graph_emit) begin
            r_res.verdict_kind <= snlc_pkg::KIND_GRAPH;
            r_res.same         <= (i_item.vertex_count_a == i_item.vertex_count_b)
                                  && r_all_same;
            r_res.row_overflow <= 1'b0;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.sel_full = push_b ? (r_cnt_b == FULL) : (r_cnt_a == FULL);
        o_sts.pos_zero = (r_pos == '0);
        o_sts.rd_gt    = (rd_sel > r_value);
        o_sts.row_ok   = !r_ovf && (r_cnt_a == r_cnt_b);
        o_sts.k_done   = (r_k == r_cnt_a);
        o_sts.rd_eq    = (r_rd_a == r_rd_b);
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

@@ hdl/sorted_neighbor_list_compare_unit.sv @@
// Compares two graphs row by row. Push beats insert a neighbor into the
// sorted list of graph A or B; a close beat gives a row verdict, and a
// finish beat gives the graph verdict. A beat is taken when start is high
// and busy is low. A push moves past larger entries in the list memory,
// since each step reads one entry and writes one back, until the new
// neighbor fits; a push to a full list writes nothing to the list. A
// close gives its verdict without reading the lists when the row
// overflowed or the lengths differ. Otherwise both lists are read side by
// side, entry by entry, up to the end of the row or the first mismatch.
// Each verdict is flagged by o_res_strobe for exactly one cycle, the
// cycle after the deciding step; the receiver has no way to stall it, so
// it must take every result beat as it comes.
module sorted_neighbor_list_compare_unit #(
    parameter int MAX_DEGREE = snlc_pkg::MAX_DEGREE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  snlc_pkg::t_item  i_item,
    output logic             o_res_strobe,
    output snlc_pkg::t_res   o_res
);

    snlc_pkg::t_cmd cmd;
    snlc_pkg::t_sts sts;
    logic           accept;

    assign accept = start && !busy;

    // Sequencer.
    snlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_item.operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    // Lists, counters and result register.
    snlc_dpath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule

@@ hdl/snlc_checker.sv @@
module snlc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input snlc_pkg::t_item i_item,
    input logic            o_res_strobe,
    input snlc_pkg::t_res  o_res
);

    logic acc_push;
    logic acc_close;
    logic acc_finish;

    assign acc_push   = start && !busy &&
                        ((i_item.operation == snlc_pkg::OP_PUSH_A) ||
                         (i_item.operation == snlc_pkg::OP_PUSH_B));
    assign acc_close  = start && !busy && (i_item.operation == snlc_pkg::OP_CLOSE);
    assign acc_finish = start && !busy && (i_item.operation == snlc_pkg::OP_FINISH);

    // A push beat never produces a result.
    a_push_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_push |=> !o_res_strobe)
        else $error("result after push beat");

    // A finish beat gives a graph verdict on the next cycle.
    a_finish_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_finish |=> o_res_strobe && (o_res.verdict_kind == snlc_pkg::KIND_GRAPH)
                       && !o_res.row_overflow)
        else $error("missing graph verdict after finish");

    // A close beat either answers at once or keeps the unit busy comparing.
    a_close_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_close |=> (o_res_strobe && (o_res.verdict_kind == snlc_pkg::KIND_ROW))
                      || busy)
        else $error("close beat neither answered nor in progress");

    // An overflowed row is never judged equal.
    a_ovf_unequal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_res.verdict_kind == snlc_pkg::KIND_ROW) && o_res.row_overflow)
        |-> !o_res.same)
        else $error("overflowed row reported as equal");

endmodule

bind sorted_neighbor_list_compare_unit snlc_checker u_snlc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_item       (i_item),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);
